FILE: hw/rtl/sds_pkg.sv
package sds_pkg;

    localparam int FREQ_W  = 32;
    localparam int SHIFT   = 10;
    localparam int F_W     = FREQ_W - SHIFT;
    localparam int PROD_W  = 30;
    localparam int DIST_W  = 20;
    localparam int RATIO_W = 8;
    localparam int CODE_W  = 9;

    // Every distinct ratio, listed by the loop position of its first divider triple.
    localparam int NUM_CAND = 44;
    localparam int NUM_LEAF = 64;
    localparam int IDX_W    = 6;
    localparam int NUM_L1   = NUM_LEAF / 4;
    localparam int NUM_L2   = NUM_L1 / 4;

    localparam logic [FREQ_W-1:0] MID_OFFSET = 32'd4688;
    localparam logic [PROD_W-1:0] VCO_MID    = 30'd2539062;
    localparam logic [PROD_W-1:0] DIST_LIMIT = 30'd585938;
    localparam logic [20:0]       IF_BASE    = 21'h100000;
    localparam logic [16:0]       SCALE_MUL  = 17'd111848;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [2:0]         d1;
        logic [2:0]         d2;
        logic [2:0]         d3;
        logic               ext_only;
    } cand_t;

    localparam cand_t CAND_TABLE [NUM_CAND] = '{
        {8'd1,   3'd1, 3'd1, 3'd1, 1'b0},
        {8'd2,   3'd1, 3'd1, 3'd2, 1'b0},
        {8'd3,   3'd1, 3'd1, 3'd3, 1'b0},
        {8'd4,   3'd1, 3'd1, 3'd4, 1'b0},
        {8'd5,   3'd1, 3'd1, 3'd5, 1'b0},
        {8'd7,   3'd1, 3'd1, 3'd7, 1'b1},
        {8'd6,   3'd1, 3'd2, 3'd3, 1'b0},
        {8'd8,   3'd1, 3'd2, 3'd4, 1'b0},
        {8'd10,  3'd1, 3'd2, 3'd5, 1'b0},
        {8'd14,  3'd1, 3'd2, 3'd7, 1'b1},
        {8'd9,   3'd1, 3'd3, 3'd3, 1'b0},
        {8'd12,  3'd1, 3'd3, 3'd4, 1'b0},
        {8'd15,  3'd1, 3'd3, 3'd5, 1'b0},
        {8'd21,  3'd1, 3'd3, 3'd7, 1'b1},
        {8'd16,  3'd1, 3'd4, 3'd4, 1'b0},
        {8'd20,  3'd1, 3'd4, 3'd5, 1'b0},
        {8'd28,  3'd1, 3'd4, 3'd7, 1'b1},
        {8'd25,  3'd1, 3'd5, 3'd5, 1'b0},
        {8'd35,  3'd1, 3'd5, 3'd7, 1'b1},
        {8'd18,  3'd2, 3'd3, 3'd3, 1'b0},
        {8'd24,  3'd2, 3'd3, 3'd4, 1'b0},
        {8'd30,  3'd2, 3'd3, 3'd5, 1'b0},
        {8'd42,  3'd2, 3'd3, 3'd7, 1'b1},
        {8'd32,  3'd2, 3'd4, 3'd4, 1'b0},
        {8'd40,  3'd2, 3'd4, 3'd5, 1'b0},
        {8'd56,  3'd2, 3'd4, 3'd7, 1'b1},
        {8'd50,  3'd2, 3'd5, 3'd5, 1'b0},
        {8'd70,  3'd2, 3'd5, 3'd7, 1'b1},
        {8'd27,  3'd3, 3'd3, 3'd3, 1'b0},
        {8'd36,  3'd3, 3'd3, 3'd4, 1'b0},
        {8'd45,  3'd3, 3'd3, 3'd5, 1'b0},
        {8'd63,  3'd3, 3'd3, 3'd7, 1'b1},
        {8'd48,  3'd3, 3'd4, 3'd4, 1'b0},
        {8'd60,  3'd3, 3'd4, 3'd5, 1'b0},
        {8'd84,  3'd3, 3'd4, 3'd7, 1'b1},
        {8'd75,  3'd3, 3'd5, 3'd5, 1'b0},
        {8'd105, 3'd3, 3'd5, 3'd7, 1'b1},
        {8'd64,  3'd4, 3'd4, 3'd4, 1'b0},
        {8'd80,  3'd4, 3'd4, 3'd5, 1'b0},
        {8'd112, 3'd4, 3'd4, 3'd7, 1'b1},
        {8'd100, 3'd4, 3'd5, 3'd5, 1'b0},
        {8'd140, 3'd4, 3'd5, 3'd7, 1'b1},
        {8'd125, 3'd5, 3'd5, 3'd5, 1'b1},
        {8'd175, 3'd5, 3'd5, 3'd7, 1'b1}
    };

    typedef struct packed {
        logic              ok;
        logic [DIST_W-1:0] delta;
        logic [IDX_W-1:0]  idx;
    } node_t;

    typedef struct packed {
        logic               tune_ok;
        logic [CODE_W-1:0]  divider_code;
        logic [RATIO_W-1:0] division_ratio;
        logic [FREQ_W-1:0]  base_freq;
        logic [20:0]        if_word;
        logic [24:0]        phy_scale_word;
        logic [31:0]        phy_mixed_word;
        logic [8:0]         spacing_word;
        logic               high_band;
    } result_t;

    // The left node always comes earlier in loop order, so it keeps ties.
    function automatic node_t node_pick(input node_t left, input node_t right);
        if (right.ok && (!left.ok || (right.delta < left.delta))) begin
            return right;
        end
        return left;
    endfunction

    function automatic node_t node_min4(input node_t n0, input node_t n1,
                                        input node_t n2, input node_t n3);
        return node_pick(node_pick(n0, n1), node_pick(n2, n3));
    endfunction

endpackage

FILE: hw/rtl/sds_cand.sv
module sds_cand import sds_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [FREQ_W-1:0]          in_base,
    input  logic                       in_ext,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [FREQ_W-1:0]          out_base,
    output node_t [NUM_LEAF-1:0]       out_leaf
);

    logic                prod_valid_reg, prod_valid_next;
    logic                prod_ready;
    logic                prod_ext_reg;
    logic [FREQ_W-1:0]   prod_base_reg;
    logic [PROD_W-1:0]   prod_reg  [NUM_CAND];
    logic [PROD_W-1:0]   prod_next [NUM_CAND];
    logic [F_W-1:0]      freq;

    logic                dist_valid_reg, dist_valid_next;
    logic                dist_ready;
    logic [FREQ_W-1:0]   dist_base_reg;
    node_t [NUM_LEAF-1:0] leaf_reg, leaf_next;

    assign freq       = in_base[FREQ_W-1:SHIFT];
    assign dist_ready = !dist_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || dist_ready;
    assign in_ready   = prod_ready;

    assign prod_valid_next = prod_ready ? in_valid : prod_valid_reg;
    assign dist_valid_next = dist_ready ? prod_valid_reg : dist_valid_reg;

    // VCO product of the reduced frequency for each candidate ratio.
    for (genvar g = 0; g < NUM_CAND; g++) begin : g_prod
        assign prod_next[g] = PROD_W'(freq) * PROD_W'(CAND_TABLE[g].ratio);
    end

    for (genvar g = 0; g < NUM_LEAF; g++) begin : g_leaf
        if (g < NUM_CAND) begin : g_cand
            logic [PROD_W-1:0] abs_dist;
            assign abs_dist = (prod_reg[g] >= VCO_MID) ? (prod_reg[g] - VCO_MID)
                                                       : (VCO_MID - prod_reg[g]);
            assign leaf_next[g].ok    = (abs_dist < DIST_LIMIT)
                                        && (prod_ext_reg || !CAND_TABLE[g].ext_only);
            assign leaf_next[g].delta = abs_dist[DIST_W-1:0];
            assign leaf_next[g].idx   = IDX_W'(g);
        end else begin : g_pad
            assign leaf_next[g].ok    = 1'b0;
            assign leaf_next[g].delta = '0;
            assign leaf_next[g].idx   = IDX_W'(g);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            dist_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            dist_valid_reg <= dist_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && prod_ready) begin
            prod_base_reg <= in_base;
            prod_ext_reg  <= in_ext;
            prod_reg      <= prod_next;
        end
        if (prod_valid_reg && dist_ready) begin
            dist_base_reg <= prod_base_reg;
            leaf_reg      <= leaf_next;
        end
    end

    assign out_valid = dist_valid_reg;
    assign out_base  = dist_base_reg;
    assign out_leaf  = leaf_reg;

endmodule

FILE: hw/rtl/sds_tree.sv
module sds_tree import sds_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FREQ_W-1:0]     in_base,
    input  node_t [NUM_LEAF-1:0]  in_leaf,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FREQ_W-1:0]     out_base,
    output node_t                 out_win
);

    logic                 l1_valid_reg, l1_valid_next, l1_ready;
    logic [FREQ_W-1:0]    l1_base_reg;
    node_t [NUM_L1-1:0]   l1_reg, l1_next;

    logic                 l2_valid_reg, l2_valid_next, l2_ready;
    logic [FREQ_W-1:0]    l2_base_reg;
    node_t [NUM_L2-1:0]   l2_reg, l2_next;

    logic                 l3_valid_reg, l3_valid_next, l3_ready;
    logic [FREQ_W-1:0]    l3_base_reg;
    node_t                l3_reg, l3_next;

    assign l3_ready = !l3_valid_reg || out_ready;
    assign l2_ready = !l2_valid_reg || l3_ready;
    assign l1_ready = !l1_valid_reg || l2_ready;
    assign in_ready = l1_ready;

    assign l1_valid_next = l1_ready ? in_valid : l1_valid_reg;
    assign l2_valid_next = l2_ready ? l1_valid_reg : l2_valid_reg;
    assign l3_valid_next = l3_ready ? l2_valid_reg : l3_valid_reg;

    // Groups are contiguous and in order, so the earliest candidate wins a tie.
    for (genvar g = 0; g < NUM_L1; g++) begin : g_l1
        assign l1_next[g] = node_min4(in_leaf[4*g], in_leaf[4*g+1],
                                      in_leaf[4*g+2], in_leaf[4*g+3]);
    end

    for (genvar g = 0; g < NUM_L2; g++) begin : g_l2
        assign l2_next[g] = node_min4(l1_reg[4*g], l1_reg[4*g+1],
                                      l1_reg[4*g+2], l1_reg[4*g+3]);
    end

    assign l3_next = node_min4(l2_reg[0], l2_reg[1], l2_reg[2], l2_reg[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_valid_reg <= 1'b0;
            l2_valid_reg <= 1'b0;
            l3_valid_reg <= 1'b0;
        end else begin
            l1_valid_reg <= l1_valid_next;
            l2_valid_reg <= l2_valid_next;
            l3_valid_reg <= l3_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && l1_ready) begin
            l1_base_reg <= in_base;
            l1_reg      <= l1_next;
        end
        if (l1_valid_reg && l2_ready) begin
            l2_base_reg <= l1_base_reg;
            l2_reg      <= l2_next;
        end
        if (l2_valid_reg && l3_ready) begin
            l3_base_reg <= l2_base_reg;
            l3_reg      <= l3_next;
        end
    end

    assign out_valid = l3_valid_reg;
    assign out_base  = l3_base_reg;
    assign out_win   = l3_reg;

endmodule

FILE: hw/rtl/sds_words.sv
module sds_words import sds_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FREQ_W-1:0] in_base,
    input  node_t             in_win,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_result
);

    logic    res_valid_reg, res_valid_next;
    logic    res_ready;
    result_t res_reg, res_next;

    cand_t              ent;
    logic [RATIO_W-1:0] ratio;
    logic [2:0]         c1, c2;
    logic [CODE_W-1:0]  code;

    assign res_ready      = !res_valid_reg || out_ready;
    assign in_ready       = res_ready;
    assign res_valid_next = res_ready ? in_valid : res_valid_reg;

    always_comb begin
        ent      = CAND_TABLE[in_win.idx];
        ratio    = ent.ratio;
        // A divider of one is written as zero in the first two code digits.
        c1       = (ent.d1 == 3'd1) ? 3'd0 : ent.d1;
        c2       = (ent.d2 == 3'd1) ? 3'd0 : ent.d2;
        code     = {c1, c2, ent.d3};
        res_next = '0;
        if (in_win.ok) begin
            res_next.tune_ok        = 1'b1;
            res_next.divider_code   = code;
            res_next.division_ratio = ratio;
            res_next.base_freq      = in_base;
            res_next.if_word        = IF_BASE | (21'(ratio) << 11);
            res_next.phy_scale_word = 25'(SCALE_MUL) * 25'(ratio);
            res_next.phy_mixed_word = (32'(ratio) << 25) | (32'(ratio) << 11);
            res_next.spacing_word   = {ratio, 1'b0};
            res_next.high_band      = (code == 9'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && res_ready) begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

endmodule

FILE: hw/rtl/synth_divider_search.sv
// Synthesizer divider search. Each transfer on the s_ side carries a tuning frequency in Hz;
// each produces exactly one transfer on the m_ side, in order. While the output is not stalled,
// the block takes one frequency every cycle: an input register, two candidate stages (44
// constant products of the reduced frequency, then their distances from the VCO mid point),
// a three-stage registered 4:1 minimum tree and the result register form a pipeline whose
// stages each hold while the next one is full, so bubbles close up under back-pressure.
// m_tuser high means a divider triple was found; when it is low all of m_tdata is zero.
// cfg_wr_en/cfg_wr_data set the extended divider mode and take effect for frequencies
// accepted after the write.
module synth_divider_search import sds_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,   // extended_dividers
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,       // [31:0] tune_freq
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,       // [8:0] divider_code, [16:9] division_ratio,
                                        // [48:17] base_freq, [69:49] if_word,
                                        // [94:70] phy_scale_word, [126:95] phy_mixed_word,
                                        // [135:127] spacing_word, [136] high_band, rest zero
    output logic         m_tuser        // [0] tune_ok
);

    logic              ext_reg;
    logic              in_valid_reg, in_valid_next, in_ready;
    logic [FREQ_W-1:0] in_base_reg;
    logic              in_ext_reg;

    logic                 cand_in_ready, cand_valid;
    logic [FREQ_W-1:0]    cand_base;
    node_t [NUM_LEAF-1:0] cand_leaf;

    logic              tree_in_ready, tree_valid;
    logic [FREQ_W-1:0] tree_base;
    node_t             tree_win;

    logic    words_in_ready;
    result_t result;

    assign in_ready      = !in_valid_reg || cand_in_ready;
    assign s_tready      = in_ready;
    assign in_valid_next = in_ready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_reg      <= 1'b0;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ext_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && in_ready) begin
            in_base_reg <= s_tdata - MID_OFFSET;
            in_ext_reg  <= ext_reg;
        end
    end

    sds_cand u_cand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (cand_in_ready),
        .in_base   (in_base_reg),
        .in_ext    (in_ext_reg),
        .out_valid (cand_valid),
        .out_ready (tree_in_ready),
        .out_base  (cand_base),
        .out_leaf  (cand_leaf)
    );

    sds_tree u_tree (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cand_valid),
        .in_ready  (tree_in_ready),
        .in_base   (cand_base),
        .in_leaf   (cand_leaf),
        .out_valid (tree_valid),
        .out_ready (words_in_ready),
        .out_base  (tree_base),
        .out_win   (tree_win)
    );

    sds_words u_words (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (tree_valid),
        .in_ready   (words_in_ready),
        .in_base    (tree_base),
        .in_win     (tree_win),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {7'd0, result.high_band, result.spacing_word, result.phy_mixed_word,
                      result.phy_scale_word, result.if_word, result.base_freq,
                      result.division_ratio, result.divider_code};
    assign m_tuser = result.tune_ok;

endmodule

FILE: hw/rtl/sds_checker.sv
module sds_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic         m_tuser
);

    // A stalled result transfer keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // When no divider triple was found, every data field is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 144'd0)
        else $error("not-found result carries data");

    // A found result's spacing, band and IF words match ratio and code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[16:9] != 8'd0)
            && (m_tdata[135:127] == {m_tdata[16:9], 1'b0})
            && (m_tdata[136] == (m_tdata[8:0] == 9'd1))
            && (m_tdata[69:49] == (21'h100000 | {2'd0, m_tdata[16:9], 11'd0})))
        else $error("found result has inconsistent words");

endmodule

bind synth_divider_search sds_checker u_sds_checker (.*);
